@@ hdl/bfpa_pkg.sv @@
package bfpa_pkg;

   localparam int PAGE_BYTES = 4096;
   localparam int PAGE_SHIFT = 12;
   localparam int DATA_W     = 22;
   localparam int STATUS_W   = 2;
   localparam int HEAP_W     = 11;

   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NOMEM   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BADHNDL = 2'd2;

   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

endpackage

@@ hdl/bfpa_table.sv @@
// Chunk table memory: one write port, one registered read port.
module bfpa_table #(
   parameter int DEPTH = 64,
   parameter int AW    = 6,
   parameter int EW    = 32
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [EW-1:0] wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [EW-1:0] rd_data
);

   logic [EW-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

@@ hdl/best_fit_page_allocator.sv @@
// Channel   Ports                                           Direction
// request   start, busy, req_func/request_bytes/handle      in (busy out)
// result    rsp_valid, rsp_data_offset/status/heap_pages    out
//
// A search pass reads one table entry per cycle through all N chunks, N the chunk
// count; then a split or merge shifts the tail one entry at a time (read, then
// write); a free that merges both neighbors shifts the tail twice. A null free
// (handle zero) skips the search and goes straight to the result.
// Reset (synchronous, active high) clears chunk count, heap top and control state.
// Busy stays high through the rsp_valid cycle and drops on the next; the result
// receiver cannot stall, each result stands for one cycle.
module best_fit_page_allocator #(
   parameter int MAX_CHUNKS   = 64,
   parameter int MAX_PAGES    = 1024,
   parameter int HEADER_BYTES = 24
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic                           req_func,
   input  logic [21:0]                    req_request_bytes,
   input  logic [21:0]                    req_handle,
   output logic                           rsp_valid,
   output logic [bfpa_pkg::DATA_W-1:0]    rsp_data_offset,
   output logic [bfpa_pkg::STATUS_W-1:0]  rsp_status,
   output logic [bfpa_pkg::HEAP_W-1:0]    rsp_heap_pages
);

   localparam int AW = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
   localparam int CW = $clog2(MAX_CHUNKS + 1);
   localparam int PW = $clog2(MAX_PAGES + 1);
   localparam int EW = 2 * PW + 1;
   localparam int NW = 24 - bfpa_pkg::PAGE_SHIFT + 1;
   localparam int XW = (PW > NW) ? PW + 1 : NW + 1;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_SRD   = 4'd1;
   localparam logic [3:0] S_SCMP  = 4'd2;
   localparam logic [3:0] S_DEC   = 4'd3;
   localparam logic [3:0] S_MRD   = 4'd4;
   localparam logic [3:0] S_MWR   = 4'd5;
   localparam logic [3:0] S_WR    = 4'd6;
   localparam logic [3:0] S_RSP   = 4'd7;
   localparam logic [3:0] S_FRD   = 4'd8;
   localparam logic [3:0] S_FCHK  = 4'd9;

   // Generic op: remove (shift down from idx) or insert (shift up to idx)
   localparam logic [1:0] OP_NONE = 2'd0;
   localparam logic [1:0] OP_INS  = 2'd1;
   localparam logic [1:0] OP_DEL  = 2'd2;

   logic [3:0]  state_ff, state_in;
   logic [CW-1:0] total_ff, total_in;
   logic [PW-1:0] top_ff, top_in;
   logic        func_ff, func_in;
   logic [21:0] handle_ff, handle_in;
   logic [NW-1:0] need_ff, need_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic        found_ff, found_in;
   logic [CW-1:0] best_ff, best_in;
   logic [PW-1:0] bcnt_ff, bcnt_in;
   logic [PW-1:0] bstart_ff, bstart_in;
   logic [EW-1:0] cur_ff, cur_in;
   logic [EW-1:0] ins_ff, ins_in;
   logic [1:0]  op_ff, op_in;
   logic [CW-1:0] opidx_ff, opidx_in;
   logic [1:0]  phase_ff, phase_in;
   logic [CW-1:0] fidx_ff, fidx_in;
   logic [bfpa_pkg::DATA_W-1:0]   off_ff, off_in;
   logic [bfpa_pkg::STATUS_W-1:0] st_ff, st_in;
   logic        vld_ff, vld_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [EW-1:0] wr_data, rd_data;

   bfpa_table #(.DEPTH(MAX_CHUNKS), .AW(AW), .EW(EW)) u_table (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   // entry layout: {in_use, count, start}
   logic [PW-1:0] rd_start, rd_count;
   logic          rd_used;
   assign rd_start = rd_data[PW-1:0];
   assign rd_count = rd_data[2*PW-1:PW];
   assign rd_used  = rd_data[EW-1];

   function automatic logic [bfpa_pkg::DATA_W-1:0] data_of(input logic [PW-1:0] sp);
      logic [39:0] v;
      v = ({24'd0, 16'(sp)} << bfpa_pkg::PAGE_SHIFT) + 40'(HEADER_BYTES);
      return v[bfpa_pkg::DATA_W-1:0];
   endfunction

   logic [23:0] bytes_w;
   logic [NW-1:0] need_w;
   assign bytes_w = 24'(req_request_bytes) + 24'(HEADER_BYTES) + 24'(bfpa_pkg::PAGE_BYTES - 1);
   assign need_w  = (bytes_w[23:bfpa_pkg::PAGE_SHIFT] == '0) ? NW'(1)
                  : NW'(bytes_w[23:bfpa_pkg::PAGE_SHIFT]);

   logic [PW-1:0] left_w;
   logic          split_ok;
   logic [PW+13:0] left_bytes;
   assign left_w    = bcnt_ff - PW'(need_ff);
   assign left_bytes = (PW+14)'(left_w) << bfpa_pkg::PAGE_SHIFT;
   assign split_ok  = (left_bytes >= (PW+14)'(bfpa_pkg::PAGE_BYTES + HEADER_BYTES))
                    && (32'(total_ff) < MAX_CHUNKS);
   logic [XW-1:0] grow_w;
   assign grow_w = XW'(top_ff) + XW'(need_ff);

   always_comb begin
      state_in = state_ff; total_in = total_ff; top_in = top_ff;
      func_in = func_ff; handle_in = handle_ff; need_in = need_ff;
      idx_in = idx_ff; found_in = found_ff; best_in = best_ff;
      bcnt_in = bcnt_ff; bstart_in = bstart_ff; cur_in = cur_ff;
      ins_in = ins_ff; op_in = op_ff; opidx_in = opidx_ff; phase_in = phase_ff;
      fidx_in = fidx_ff; off_in = off_ff; st_in = st_ff; vld_in = 1'b0;
      wr_en = 1'b0; wr_addr = '0; wr_data = '0; rd_addr = AW'(idx_ff);
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               func_in = req_func; handle_in = req_handle; need_in = need_w;
               idx_in = '0; found_in = 1'b0; off_in = '0; st_in = bfpa_pkg::ST_OK;
               op_in = OP_NONE; phase_in = 2'd0;
               rd_addr = '0;
               if (req_func == bfpa_pkg::FUNC_FREE && req_handle == '0) state_in = S_RSP;
               else if (total_ff == '0) state_in = S_DEC;
               else state_in = S_SCMP;
            end
         end
         S_SRD: begin
            rd_addr = AW'(idx_ff);
            state_in = S_SCMP;
         end
         S_SCMP: begin
            // compare the entry read last cycle
            if (func_ff == bfpa_pkg::FUNC_ALLOC) begin
               if (!rd_used && XW'(rd_count) >= XW'(need_ff)
                   && (!found_ff || rd_count < bcnt_ff)) begin
                  found_in = 1'b1; best_in = idx_ff;
                  bcnt_in = rd_count; bstart_in = rd_start;
               end
            end else if (!found_ff && rd_used && data_of(rd_start) == handle_ff) begin
               found_in = 1'b1; best_in = idx_ff; bcnt_in = rd_count; bstart_in = rd_start;
            end
            idx_in = idx_ff + 1'b1;
            rd_addr = AW'(idx_ff + 1'b1);
            if (idx_ff + 1'b1 == total_ff) state_in = S_DEC;
         end
         S_DEC: begin
            if (func_ff == bfpa_pkg::FUNC_ALLOC) begin
               if (found_ff) begin
                  off_in = data_of(bstart_ff);
                  wr_en = 1'b1; wr_addr = AW'(best_ff);
                  if (split_ok) begin
                     wr_data = {1'b1, PW'(need_ff), bstart_ff};
                     ins_in = {1'b0, left_w, bstart_ff + PW'(need_ff)};
                     op_in = OP_INS; opidx_in = best_ff + 1'b1;
                     idx_in = total_ff; state_in = S_MRD;
                  end else begin
                     wr_data = {1'b1, bcnt_ff, bstart_ff};
                     state_in = S_RSP;
                  end
               end else if (grow_w > XW'(MAX_PAGES) || 32'(total_ff) >= MAX_CHUNKS) begin
                  st_in = bfpa_pkg::ST_NOMEM; state_in = S_RSP;
               end else begin
                  wr_en = 1'b1; wr_addr = AW'(total_ff);
                  wr_data = {1'b1, PW'(need_ff), top_ff};
                  off_in = data_of(top_ff);
                  top_in = PW'(grow_w); total_in = total_ff + 1'b1;
                  state_in = S_RSP;
               end
            end else if (!found_ff) begin
               st_in = bfpa_pkg::ST_BADHNDL; state_in = S_RSP;
            end else begin
               // free: phase 0 check next neighbor
               fidx_in = best_ff; cur_in = {1'b0, bcnt_ff, bstart_ff};
               wr_en = 1'b1; wr_addr = AW'(best_ff); wr_data = {1'b0, bcnt_ff, bstart_ff};
               phase_in = 2'd0; state_in = S_FRD;
            end
         end
         S_FRD: begin
            // phase0: read i+1; phase1: read i-1; phase2: read last
            unique case (phase_ff)
               2'd0: rd_addr = AW'(fidx_ff + 1'b1);
               2'd1: rd_addr = AW'(fidx_ff - 1'b1);
               default: rd_addr = AW'(total_ff - 1'b1);
            endcase
            state_in = S_FCHK;
         end
         S_FCHK: begin
            unique case (phase_ff)
               2'd0: begin
                  phase_in = 2'd1;
                  if (fidx_ff + 1'b1 < total_ff && !rd_used) begin
                     cur_in = {1'b0, cur_ff[2*PW-1:PW] + rd_count, cur_ff[PW-1:0]};
                     wr_en = 1'b1; wr_addr = AW'(fidx_ff);
                     wr_data = {1'b0, cur_ff[2*PW-1:PW] + rd_count, cur_ff[PW-1:0]};
                     op_in = OP_DEL; opidx_in = fidx_ff + 1'b1; idx_in = fidx_ff + 1'b1;
                     state_in = S_MRD;
                  end else if (fidx_ff != '0) state_in = S_FRD;
                  else begin phase_in = 2'd2; state_in = S_FRD; end
               end
               2'd1: begin
                  phase_in = 2'd2;
                  state_in = S_FRD;
                  // the first chunk has no previous neighbor
                  if (fidx_ff != '0 && !rd_used) begin
                     wr_en = 1'b1; wr_addr = AW'(fidx_ff - 1'b1);
                     wr_data = {1'b0, rd_count + cur_ff[2*PW-1:PW], rd_start};
                     op_in = OP_DEL; opidx_in = fidx_ff; idx_in = fidx_ff;
                     state_in = S_MRD;
                  end
               end
               default: begin
                  if (total_ff != '0 && !rd_used) begin
                     top_in = rd_start; total_in = total_ff - 1'b1;
                  end
                  state_in = S_RSP;
               end
            endcase
         end
         S_MRD: begin
            // shift pass: insert moves k-1 -> k downward; delete moves k+1 -> k
            op_in = op_ff;
            if (op_ff == OP_INS) begin
               if (idx_ff == opidx_ff) begin
                  wr_en = 1'b1; wr_addr = AW'(idx_ff); wr_data = ins_ff;
                  total_in = total_ff + 1'b1; op_in = OP_NONE; state_in = S_RSP;
               end else begin
                  rd_addr = AW'(idx_ff - 1'b1); state_in = S_MWR;
               end
            end else begin
               if (idx_ff + 1'b1 >= total_ff) begin
                  total_in = total_ff - 1'b1; op_in = OP_NONE;
                  if (opidx_ff == fidx_ff) fidx_in = fidx_ff - 1'b1;
                  state_in = S_FRD;
               end else begin
                  rd_addr = AW'(idx_ff + 1'b1); state_in = S_MWR;
               end
            end
         end
         S_MWR: begin
            wr_en = 1'b1; wr_addr = AW'(idx_ff); wr_data = rd_data;
            idx_in = (op_ff == OP_INS) ? idx_ff - 1'b1 : idx_ff + 1'b1;
            state_in = S_MRD;
         end
         S_RSP: begin
            vld_in = 1'b1; state_in = S_WR;
         end
         S_WR: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; total_ff <= '0; top_ff <= '0; vld_ff <= 1'b0;
         op_ff <= OP_NONE; phase_ff <= '0; found_ff <= 1'b0;
      end else begin
         state_ff <= state_in; total_ff <= total_in; top_ff <= top_in; vld_ff <= vld_in;
         op_ff <= op_in; phase_ff <= phase_in; found_ff <= found_in;
      end
      func_ff <= func_in; handle_ff <= handle_in; need_ff <= need_in; idx_ff <= idx_in;
      best_ff <= best_in; bcnt_ff <= bcnt_in; bstart_ff <= bstart_in;
      cur_ff <= cur_in; ins_ff <= ins_in; opidx_ff <= opidx_in; fidx_ff <= fidx_in;
      off_ff <= off_in; st_ff <= st_in;
   end

   assign busy            = (state_ff != S_IDLE);
   assign rsp_valid       = vld_ff;
   assign rsp_data_offset = off_ff;
   assign rsp_status      = st_ff;
   assign rsp_heap_pages  = bfpa_pkg::HEAP_W'(top_ff);

`ifndef SYNTHESIS
   a_total_max: assert property (@(posedge clock) disable iff (reset)
      32'(total_ff) <= MAX_CHUNKS) else $error("chunk count overflow");
   a_top_max: assert property (@(posedge clock) disable iff (reset)
      32'(top_ff) <= MAX_PAGES) else $error("heap top overflow");
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("result outside request");
   a_rsp_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result repeated");
   a_nomem_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != bfpa_pkg::ST_OK |-> rsp_data_offset == '0)
      else $error("failed request with offset");
`endif

endmodule

@@ tb/sv/tb_best_fit_page_allocator.sv @@
module tb_best_fit_page_allocator;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_CHUNKS   = 64;
   localparam int MAX_PAGES    = 1024;
   localparam int HEADER_BYTES = 24;
   localparam int RANDOM_ITEMS = 1830;
   localparam int DRAIN_CYCLES = 4 * MAX_CHUNKS + 40;

   // Tracks the chunk table and heap top, and holds the results still owed.
   class alloc_scoreboard;
      int start_pg[MAX_CHUNKS];
      int pages[MAX_CHUNKS];
      bit in_use[MAX_CHUNKS];
      int total;
      int top;
      logic [bfpa_pkg::DATA_W-1:0]   want_off[$];
      logic [bfpa_pkg::STATUS_W-1:0] want_st[$];
      logic [bfpa_pkg::HEAP_W-1:0]   want_heap[$];

      function new();
         total = 0;
         top   = 0;
      endfunction

      function logic [bfpa_pkg::DATA_W-1:0] offset_of(int i);
         return bfpa_pkg::DATA_W'(start_pg[i] * bfpa_pkg::PAGE_BYTES + HEADER_BYTES);
      endfunction

      function void drop_entry(int i);
         for (int k = i; k + 1 < total; k++) begin
            start_pg[k] = start_pg[k+1];
            pages[k]    = pages[k+1];
            in_use[k]   = in_use[k+1];
         end
         total--;
      endfunction

      function void add_entry(int i, int s, int c, bit u);
         for (int k = total; k > i; k--) begin
            start_pg[k] = start_pg[k-1];
            pages[k]    = pages[k-1];
            in_use[k]   = in_use[k-1];
         end
         start_pg[i] = s;
         pages[i]    = c;
         in_use[i]   = u;
         total++;
      endfunction

      function void allocate(int bytes, output logic [bfpa_pkg::DATA_W-1:0] off,
                             output logic [bfpa_pkg::STATUS_W-1:0] st);
         int need;
         int best;
         int left;
         need = (bytes + HEADER_BYTES + bfpa_pkg::PAGE_BYTES - 1) / bfpa_pkg::PAGE_BYTES;
         best = -1;
         off  = '0;
         st   = bfpa_pkg::ST_OK;
         if (need == 0) need = 1;
         for (int i = 0; i < total; i++) begin
            if (!in_use[i] && pages[i] >= need && (best < 0 || pages[i] < pages[best]))
               best = i;
         end
         if (best >= 0) begin
            left = pages[best] - need;
            if (left * bfpa_pkg::PAGE_BYTES >= bfpa_pkg::PAGE_BYTES + HEADER_BYTES
                && total < MAX_CHUNKS) begin
               add_entry(best + 1, start_pg[best] + need, left, 1'b0);
               pages[best] = need;
            end
            in_use[best] = 1'b1;
            off = offset_of(best);
         end else if (top + need > MAX_PAGES || total >= MAX_CHUNKS) begin
            st = bfpa_pkg::ST_NOMEM;
         end else begin
            add_entry(total, top, need, 1'b1);
            top += need;
            off = offset_of(total - 1);
         end
      endfunction

      function void release_chunk(logic [bfpa_pkg::DATA_W-1:0] handle,
                                  output logic [bfpa_pkg::STATUS_W-1:0] st);
         int hit;
         hit = -1;
         st  = bfpa_pkg::ST_OK;
         if (handle == 0) return;
         for (int i = 0; i < total && hit < 0; i++)
            if (in_use[i] && offset_of(i) == handle) hit = i;
         if (hit < 0) begin
            st = bfpa_pkg::ST_BADHNDL;
            return;
         end
         in_use[hit] = 1'b0;
         if (hit + 1 < total && !in_use[hit+1]) begin
            pages[hit] += pages[hit+1];
            drop_entry(hit + 1);
         end
         if (hit > 0 && !in_use[hit-1]) begin
            pages[hit-1] += pages[hit];
            drop_entry(hit);
         end
         if (total > 0 && !in_use[total-1]) begin
            top = start_pg[total-1];
            total--;
         end
      endfunction

      function void note_request(logic func, logic [21:0] bytes, logic [21:0] handle,
                                 output logic [bfpa_pkg::DATA_W-1:0] off,
                                 output logic [bfpa_pkg::STATUS_W-1:0] st);
         off = '0;
         if (func == bfpa_pkg::FUNC_ALLOC) allocate(int'(bytes), off, st);
         else release_chunk(handle, st);
         want_off.push_back(off);
         want_st.push_back(st);
         want_heap.push_back(bfpa_pkg::HEAP_W'(top));
      endfunction

      function bit check_result(logic [bfpa_pkg::DATA_W-1:0] off,
                                logic [bfpa_pkg::STATUS_W-1:0] st,
                                logic [bfpa_pkg::HEAP_W-1:0] heap, output string msg);
         logic [bfpa_pkg::DATA_W-1:0]   e_off;
         logic [bfpa_pkg::STATUS_W-1:0] e_st;
         logic [bfpa_pkg::HEAP_W-1:0]   e_heap;
         if (want_off.size() == 0) begin
            msg = $sformatf("result with nothing outstanding: off=%0d st=%0d heap=%0d",
                            off, st, heap);
            return 1'b0;
         end
         e_off  = want_off.pop_front();
         e_st   = want_st.pop_front();
         e_heap = want_heap.pop_front();
         if (off !== e_off || st !== e_st || heap !== e_heap) begin
            msg = $sformatf("off=%0d/%0d st=%0d/%0d heap=%0d/%0d (got/want)",
                            off, e_off, st, e_st, heap, e_heap);
            return 1'b0;
         end
         return 1'b1;
      endfunction

      function int pending();
         return want_off.size();
      endfunction
   endclass

   logic                          clock;
   logic                          reset;
   logic                          start;
   logic                          busy;
   logic                          req_func;
   logic [21:0]                   req_request_bytes;
   logic [21:0]                   req_handle;
   logic                          rsp_valid;
   logic [bfpa_pkg::DATA_W-1:0]   rsp_data_offset;
   logic [bfpa_pkg::STATUS_W-1:0] rsp_status;
   logic [bfpa_pkg::HEAP_W-1:0]   rsp_heap_pages;

   alloc_scoreboard               sb;
   int                            errors;
   logic [bfpa_pkg::DATA_W-1:0]   last_off;
   logic [bfpa_pkg::STATUS_W-1:0] last_st;
   logic [21:0]                   live[$];
   logic [21:0]                   freed[$];
   bit                            no_gaps;

   best_fit_page_allocator #(
      .MAX_CHUNKS  (MAX_CHUNKS),
      .MAX_PAGES   (MAX_PAGES),
      .HEADER_BYTES(HEADER_BYTES)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_func         (req_func),
      .req_request_bytes(req_request_bytes),
      .req_handle       (req_handle),
      .rsp_valid        (rsp_valid),
      .rsp_data_offset  (rsp_data_offset),
      .rsp_status       (rsp_status),
      .rsp_heap_pages   (rsp_heap_pages)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report(string msg);
      $display("mismatch @%0t: %s", $realtime, msg);
      errors++;
   endtask

   always @(posedge clock) begin
      string msg;
      if (!reset && rsp_valid) begin
         if (!sb.check_result(rsp_data_offset, rsp_status, rsp_heap_pages, msg))
            report(msg);
      end
   end

   function automatic int pick_gap();
      int r;
      if (no_gaps) return 0;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // Hold start until the transfer, then record it and maybe idle.
   task automatic send(logic func, logic [21:0] bytes, logic [21:0] handle);
      int gap;
      start             <= 1'b1;
      req_func          <= func;
      req_request_bytes <= bytes;
      req_handle        <= handle;
      do @(posedge clock); while (busy);
      sb.note_request(func, bytes, handle, last_off, last_st);
      if (func == bfpa_pkg::FUNC_ALLOC && last_st == bfpa_pkg::ST_OK)
         live.push_back(last_off);
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic alloc_bytes(int bytes);
      send(bfpa_pkg::FUNC_ALLOC, 22'(bytes), 22'($urandom));
   endtask

   task automatic free_handle(logic [21:0] handle);
      foreach (live[k]) begin
         if (live[k] == handle) begin
            live.delete(k);
            freed.push_back(handle);
            if (freed.size() > 16) void'(freed.pop_front());
            break;
         end
      end
      send(bfpa_pkg::FUNC_FREE, 22'($urandom), handle);
   endtask

   task automatic free_live_at(int k);
      free_handle(live[k]);
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      logic [21:0] a1;
      logic [21:0] a2;
      logic [21:0] big;
      int r;
      sb                = new();
      errors            = 0;
      no_gaps           = 1'b0;
      reset             = 1'b1;
      start             = 1'b0;
      req_func          = bfpa_pkg::FUNC_ALLOC;
      req_request_bytes = '0;
      req_handle        = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: sizes at page edges, bad frees, split and no-split, heap full
      alloc_bytes(0);
      alloc_bytes(bfpa_pkg::PAGE_BYTES - HEADER_BYTES);
      a1 = last_off;
      alloc_bytes(bfpa_pkg::PAGE_BYTES - HEADER_BYTES + 1);
      a2 = last_off;
      alloc_bytes(22'h3FFFFF);
      free_handle(22'd0);
      free_handle(22'h3FFFFF);
      alloc_bytes(10 * bfpa_pkg::PAGE_BYTES - HEADER_BYTES);
      big = last_off;
      alloc_bytes(1);
      free_handle(a2);
      free_handle(a2);
      alloc_bytes(100);
      free_handle(big);
      alloc_bytes(0);
      alloc_bytes(1000 * bfpa_pkg::PAGE_BYTES - HEADER_BYTES);
      free_handle(a1);
      alloc_bytes(2 * bfpa_pkg::PAGE_BYTES);
      wait_idle();
      while (live.size() > 0) free_live_at(live.size() - 1);
      alloc_bytes(MAX_PAGES * bfpa_pkg::PAGE_BYTES - HEADER_BYTES);
      free_live_at(0);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 150 == 0) no_gaps = ($urandom_range(0, 3) == 0);
         if (n == RANDOM_ITEMS / 2) wait_idle();
         r = $urandom_range(0, 99);
         if (r < 50 || live.size() == 0) begin
            if ($urandom_range(0, 19) == 0) alloc_bytes($urandom_range(0, 22'h3FFFFF));
            else alloc_bytes($urandom_range(0, 12 * bfpa_pkg::PAGE_BYTES));
         end else if (r < 90) begin
            free_live_at($urandom_range(0, live.size() - 1));
         end else if (r < 94 && freed.size() > 0) begin
            free_handle(freed[$urandom_range(0, freed.size() - 1)]);
         end else if (r < 97) begin
            free_handle(22'($urandom));
         end else begin
            free_handle(22'd0);
         end
      end

      wait_idle();
      if (errors == 0)
         $display("[best_fit_page_allocator] OK");
      else
         $display("[best_fit_page_allocator] ERROR");
      $finish;
   end

   initial begin
      #20ms;
      $display("[best_fit_page_allocator] ERROR");
      $finish;
   end

endmodule

@@ best_fit_page_allocator.f @@
hdl/bfpa_pkg.sv
hdl/bfpa_table.sv
hdl/best_fit_page_allocator.sv
tb/sv/tb_best_fit_page_allocator.sv
